// ===== rtl/cgbb_pkg.sv =====
// Shared types, constants and the blend function of the glyph blit block.
package cgbb_pkg;

	localparam int MAX_DIMENSION_DEF  = 4096;
	localparam int MAX_GLYPH_SIDE_DEF = 255;

	// Signed width that holds any pixel position, clip bound or buffer size.
	localparam int POS_W    = 16;
	localparam int COORD_W  = 13;
	localparam int COLOR_W  = 16;
	localparam int COV_W    = 8;
	localparam int SIDE_W   = 8;
	localparam int ADDR_W   = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int WIDTH_RST  = 480;
	localparam int HEIGHT_RST = 272;
	localparam logic signed [COORD_W-1:0] CLIP_HI_RST = 13'sd4095;

	localparam logic [COV_W-1:0]   COV_FULL   = 8'd128;
	localparam logic [COV_W-1:0]   COV_NONE   = 8'd1;
	localparam logic [COLOR_W-1:0] BLEND_MASK = 16'h0821;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEXT_COLOR    = 3'd0,
		REG_CLIP_LEFT     = 3'd1,
		REG_CLIP_TOP      = 3'd2,
		REG_CLIP_RIGHT    = 3'd3,
		REG_CLIP_BOTTOM   = 3'd4,
		REG_BUFFER_WIDTH  = 3'd5,
		REG_BUFFER_HEIGHT = 3'd6
	} reg_idx_t;

	typedef enum logic {
		KIND_START  = 1'b0,
		KIND_SAMPLE = 1'b1
	} kind_t;

	// Clip rectangle after clamping to the buffer, inclusive bounds.
	typedef struct packed {
		logic signed [POS_W-1:0] left;
		logic signed [POS_W-1:0] top;
		logic signed [POS_W-1:0] right;
		logic signed [POS_W-1:0] bottom;
	} clip_t;

	// One live sample on its way to the blend stage.
	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic [COV_W-1:0]        coverage;
		logic [COLOR_W-1:0]      old_pixel;
	} pix_t;

	function automatic logic [COLOR_W-1:0] blend(input logic [COV_W-1:0] cov,
			input logic [COLOR_W-1:0] c, input logic [COLOR_W-1:0] o);
		logic [COLOR_W:0] sum;
		logic [COLOR_W:0] mix;
		sum = {1'b0, c} + {1'b0, o};
		mix = sum ^ {1'b0, (c ^ o) & BLEND_MASK};
		if (cov > COV_FULL)
			return c;
		else if (cov > COV_NONE)
			return mix[COLOR_W:1];
		else
			return o;
	endfunction

endpackage

// ===== rtl/cgbb_cfg.sv =====
// Configuration registers and the clamped clip rectangle.
module cgbb_cfg #(
	parameter int MAX_DIMENSION = cgbb_pkg::MAX_DIMENSION_DEF,
	localparam int DW = $clog2(MAX_DIMENSION + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [cgbb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cgbb_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [cgbb_pkg::COLOR_W-1:0]    color,
	output logic [DW-1:0]                   stride,
	output cgbb_pkg::clip_t                 clip
);
	import cgbb_pkg::*;

	localparam logic [DW-1:0] W_RST =
		DW'((WIDTH_RST > MAX_DIMENSION) ? MAX_DIMENSION : WIDTH_RST);
	localparam logic [DW-1:0] H_RST =
		DW'((HEIGHT_RST > MAX_DIMENSION) ? MAX_DIMENSION : HEIGHT_RST);

	logic [COLOR_W-1:0]        text_color_q;
	logic signed [COORD_W-1:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
	logic [DW-1:0]             width_q, height_q;
	logic [COORD_W-1:0]        dim_raw;
	logic [DW-1:0]             dim_sat;
	logic signed [POS_W-1:0]   w_s, h_s, r_s, b_s, l_s, t_s;

	assign dim_raw = cfg_data[COORD_W-1:0];
	assign dim_sat = (32'(dim_raw) > MAX_DIMENSION) ? DW'(MAX_DIMENSION) : DW'(dim_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q  <= '0;
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_right_q  <= CLIP_HI_RST;
			clip_bottom_q <= CLIP_HI_RST;
			width_q       <= W_RST;
			height_q      <= H_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TEXT_COLOR:    text_color_q  <= cfg_data;
				REG_CLIP_LEFT:     clip_left_q   <= signed'(cfg_data[COORD_W-1:0]);
				REG_CLIP_TOP:      clip_top_q    <= signed'(cfg_data[COORD_W-1:0]);
				REG_CLIP_RIGHT:    clip_right_q  <= signed'(cfg_data[COORD_W-1:0]);
				REG_CLIP_BOTTOM:   clip_bottom_q <= signed'(cfg_data[COORD_W-1:0]);
				REG_BUFFER_WIDTH:  width_q       <= dim_sat;
				REG_BUFFER_HEIGHT: height_q      <= dim_sat;
				default: ;
			endcase
		end
	end

	assign w_s = signed'(POS_W'(width_q));
	assign h_s = signed'(POS_W'(height_q));
	assign l_s = POS_W'(clip_left_q);
	assign t_s = POS_W'(clip_top_q);
	assign r_s = POS_W'(clip_right_q);
	assign b_s = POS_W'(clip_bottom_q);

	always_comb begin
		clip.left   = (l_s < 0) ? '0 : l_s;
		clip.top    = (t_s < 0) ? '0 : t_s;
		clip.right  = (r_s >= w_s) ? w_s - POS_W'(1) : r_s;
		clip.bottom = (b_s >= h_s) ? h_s - POS_W'(1) : b_s;
	end

	assign color  = text_color_q;
	assign stride = width_q;

endmodule

// ===== rtl/cgbb_raster.sv =====
// Glyph raster walker: tracks origin and position, registers live samples.
module cgbb_raster #(
	parameter int MAX_GLYPH_SIDE = cgbb_pkg::MAX_GLYPH_SIDE_DEF,
	localparam int GW = $clog2(MAX_GLYPH_SIDE + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              advance,
	input  logic                              kind,
	input  logic signed [cgbb_pkg::COORD_W-1:0] glyph_x,
	input  logic signed [cgbb_pkg::COORD_W-1:0] glyph_y,
	input  logic [cgbb_pkg::SIDE_W-1:0]       glyph_cols,
	input  logic [cgbb_pkg::SIDE_W-1:0]       glyph_rows,
	input  logic [cgbb_pkg::COV_W-1:0]        coverage,
	input  logic [cgbb_pkg::COLOR_W-1:0]      old_pixel,
	output logic                              valid_s1,
	output cgbb_pkg::pix_t                    pix_s1
);
	import cgbb_pkg::*;

	logic signed [COORD_W-1:0] origin_x_q, origin_y_q;
	logic [GW-1:0]             cols_q, rows_q, col_q, row_q;
	logic [GW-1:0]             col_inc;
	logic                      live;
	logic                      sample;

	assign live    = (cols_q != '0) && (row_q < rows_q);
	assign sample  = accept && (kind == KIND_SAMPLE) && live;
	assign col_inc = col_q + GW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			cols_q     <= '0;
			rows_q     <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (accept && kind == KIND_START) begin
			origin_x_q <= glyph_x;
			origin_y_q <= glyph_y;
			cols_q <= (32'(glyph_cols) > MAX_GLYPH_SIDE) ? GW'(MAX_GLYPH_SIDE) : GW'(glyph_cols);
			rows_q <= (32'(glyph_rows) > MAX_GLYPH_SIDE) ? GW'(MAX_GLYPH_SIDE) : GW'(glyph_rows);
			col_q  <= '0;
			row_q  <= '0;
		end else if (sample) begin
			// wrap to the next glyph row at the end of a line
			if (col_inc >= cols_q) begin
				col_q <= '0;
				row_q <= row_q + GW'(1);
			end else begin
				col_q <= col_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (advance)
			valid_s1 <= sample;
	end

	always_ff @(posedge clk) begin
		if (sample) begin
			pix_s1.px        <= POS_W'(origin_x_q) + signed'(POS_W'(col_q));
			pix_s1.py        <= POS_W'(origin_y_q) + signed'(POS_W'(row_q));
			pix_s1.coverage  <= coverage;
			pix_s1.old_pixel <= old_pixel;
		end
	end

endmodule

// ===== rtl/cgbb_pixel.sv =====
// Clip test, blend and address stage feeding the result register.
module cgbb_pixel #(
	parameter int MAX_DIMENSION = cgbb_pkg::MAX_DIMENSION_DEF,
	localparam int DW = $clog2(MAX_DIMENSION + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  logic                           valid_s1,
	input  cgbb_pkg::pix_t                 pix_s1,
	input  cgbb_pkg::clip_t                clip,
	input  logic [cgbb_pkg::COLOR_W-1:0]   color,
	input  logic [DW-1:0]                  stride,
	output logic                           out_valid,
	output logic [cgbb_pkg::ADDR_W-1:0]    write_address,
	output logic [cgbb_pkg::COLOR_W-1:0]   new_pixel
);
	import cgbb_pkg::*;

	localparam int AW = 2 * DW + 1;

	logic          in_clip;
	logic [AW-1:0] lin;
	logic          out_valid_q;

	assign in_clip = (pix_s1.px >= clip.left) && (pix_s1.px <= clip.right) &&
		(pix_s1.py >= clip.top) && (pix_s1.py <= clip.bottom);

	// Both coordinates are below the buffer size whenever the pixel is inside.
	assign lin = AW'(pix_s1.py[DW-1:0] * stride) + AW'(pix_s1.px[DW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1 && in_clip;
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && in_clip) begin
			write_address <= ADDR_W'(lin);
			new_pixel     <= blend(pix_s1.coverage, color, pix_s1.old_pixel);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/clipped_glyph_blit_blend.sv =====
// Clipped glyph blit with alpha-average blend into an RGB565 frame buffer.
//
// Input channel (in_valid / in_stall): a start beat (kind 0) loads the glyph
// origin and size; sample beats (kind 1) follow in raster order, each with a
// coverage byte and the frame-buffer pixel under it.
// Output channel (out_valid / out_stall): one beat per sample that falls in
// the clamped clip rectangle, carrying the pixel index and the value to store.
// Start beats, samples outside the clip and samples past the glyph give none.
// Config channel (cfg_valid / cfg_ready): always ready; write only while idle.
// An accepted sample passes through the raster register, then through the
// clip/blend/address stage into the result register.
// Throughput is one beat per cycle while out_stall is low; the row-times-stride
// multiply and the clip compares in the second stage set the clock.
// When out_stall is held the result and the raster register hold, and
// in_stall rises once both are full.
// Reset empties the pipeline, clears the glyph (samples are dropped until a
// start beat) and loads the register reset values.
module clipped_glyph_blit_blend #(
	parameter int MAX_DIMENSION  = cgbb_pkg::MAX_DIMENSION_DEF,
	parameter int MAX_GLYPH_SIDE = cgbb_pkg::MAX_GLYPH_SIDE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cgbb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cgbb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic signed [cgbb_pkg::COORD_W-1:0] glyph_x,
	input  logic signed [cgbb_pkg::COORD_W-1:0] glyph_y,
	input  logic [cgbb_pkg::SIDE_W-1:0]         glyph_cols,
	input  logic [cgbb_pkg::SIDE_W-1:0]         glyph_rows,
	input  logic [cgbb_pkg::COV_W-1:0]          coverage,
	input  logic [cgbb_pkg::COLOR_W-1:0]        old_pixel,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [cgbb_pkg::ADDR_W-1:0]         write_address,
	output logic [cgbb_pkg::COLOR_W-1:0]        new_pixel
);
	import cgbb_pkg::*;

	localparam int DW = $clog2(MAX_DIMENSION + 1);

	logic [COLOR_W-1:0] color;
	logic [DW-1:0]      stride;
	clip_t              clip;
	logic               valid_s1;
	pix_t               pix_s1;
	logic               out_adv;
	logic               s1_adv;
	logic               accept;

	// advance the result register when empty or taken, the raster register
	// when it is empty or moves on
	assign out_adv   = !out_valid || !out_stall;
	assign s1_adv    = !valid_s1 || out_adv;
	assign in_stall  = !s1_adv;
	assign accept    = in_valid && s1_adv;
	assign cfg_ready = 1'b1;

	cgbb_cfg #(.MAX_DIMENSION(MAX_DIMENSION)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.color     (color),
		.stride    (stride),
		.clip      (clip)
	);

	cgbb_raster #(.MAX_GLYPH_SIDE(MAX_GLYPH_SIDE)) u_raster (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.advance    (s1_adv),
		.kind       (kind),
		.glyph_x    (glyph_x),
		.glyph_y    (glyph_y),
		.glyph_cols (glyph_cols),
		.glyph_rows (glyph_rows),
		.coverage   (coverage),
		.old_pixel  (old_pixel),
		.valid_s1   (valid_s1),
		.pix_s1     (pix_s1)
	);

	cgbb_pixel #(.MAX_DIMENSION(MAX_DIMENSION)) u_pixel (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (out_adv),
		.valid_s1      (valid_s1),
		.pix_s1        (pix_s1),
		.clip          (clip),
		.color         (color),
		.stride        (stride),
		.out_valid     (out_valid),
		.write_address (write_address),
		.new_pixel     (new_pixel)
	);

endmodule
